// ----- design/stbrm_pkg.sv -----
// ----------------------------------------------------------------------------
// stbrm_pkg
// shared widths, codes, reset values and handshake structs of the rate meter
// ----------------------------------------------------------------------------
package stbrm_pkg;

	// field widths
	localparam int KIND_W     = 2;
	localparam int STAMP_W    = 64;
	localparam int FREQ_W     = 40;
	localparam int FRATE_W    = 10;
	localparam int GAIN_W     = 23;
	localparam int AVG_W      = 5;
	localparam int DT_W       = 48;
	localparam int SEC_W      = 32;
	localparam int RATE_W     = 32;
	localparam int TIME_W     = 64;
	localparam int PROD_W     = STAMP_W + GAIN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = DT_W + SEC_W + RATE_W + TIME_W;

	// divider remainder and divisor width
	localparam int DIV_R_W   = 64;
	localparam int DIV_CNT_W = 7;

	localparam int HISTORY_DEPTH_DEF = 16;

	// reset values of the registers
	localparam logic              FIXED_MODE_RST = 1'b0;
	localparam logic [FREQ_W-1:0] TICK_FREQ_RST  = 40'd1000000000;
	localparam logic [FRATE_W-1:0] FIXED_RATE_RST = 10'd60;
	localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 23'd65536;
	localparam logic [AVG_W-1:0]  AVG_COUNT_RST  = 5'd0;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam logic [DT_W-1:0]   DT_MAX   = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_PAUSE  = 2'd1,
		KIND_RESUME = 2'd2,
		KIND_RESET  = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIXED_MODE    = 3'd0,
		CFG_TICK_FREQ     = 3'd1,
		CFG_FIXED_RATE    = 3'd2,
		CFG_RATE_GAIN     = 3'd3,
		CFG_AVERAGE_COUNT = 3'd4
	} cfg_idx_t;

	typedef logic [DIV_CNT_W-1:0] div_cnt_t;

	typedef struct packed {
		logic     start;
		div_cnt_t count;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

endpackage

// ----- design/stbrm_div.sv -----
// ----------------------------------------------------------------------------
// stbrm_div
// restoring divider, one quotient bit per cycle, dividend shifted in msb first
// ----------------------------------------------------------------------------
module stbrm_div #(
	parameter int DW = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stbrm_pkg::div_cmd_t               cmd,
	input  logic [stbrm_pkg::DIV_R_W-1:0]     rem_init,
	input  logic [stbrm_pkg::DIV_R_W-1:0]     divisor,
	input  logic [DW-1:0]                     dividend,
	output stbrm_pkg::seq_stat_t              stat,
	output logic [DW-1:0]                     quotient,
	output logic [stbrm_pkg::DIV_R_W-1:0]     remainder
);

	localparam int RW = stbrm_pkg::DIV_R_W;

	logic                      busy_q;
	logic                      done_q;
	stbrm_pkg::div_cnt_t       cnt_q;
	logic [RW-1:0]             rem_q;
	logic [RW-1:0]             dsr_q;
	logic [DW-1:0]             dvd_q;
	logic [DW-1:0]             quo_q;
	logic [RW:0]               trial;
	logic [RW:0]               diff;
	logic                      fit;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	// no borrow: the divisor fits into the partial remainder
	assign fit   = ~diff[RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == stbrm_pkg::div_cnt_t'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= rem_init;
			dsr_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? diff[RW-1:0] : trial[RW-1:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], fit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- design/stbrm_mul.sv -----
// ----------------------------------------------------------------------------
// stbrm_mul
// shift-add multiplier of elapsed ticks by the gain, one gain bit per cycle
// ----------------------------------------------------------------------------
module stbrm_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [stbrm_pkg::STAMP_W-1:0]     a,
	input  logic [stbrm_pkg::GAIN_W-1:0]      b,
	output logic                              busy,
	output logic [stbrm_pkg::PROD_W-1:0]      product
);

	localparam int AW    = stbrm_pkg::STAMP_W;
	localparam int BW    = stbrm_pkg::GAIN_W;
	localparam int PW    = stbrm_pkg::PROD_W;
	localparam int CNT_W = $clog2(BW + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    a_q;
	logic [BW-1:0]    b_q;
	logic [PW-1:0]    acc_q;
	logic [AW:0]      sum;

	// add into the upper part, then shift the whole accumulator right
	assign sum = {1'b0, acc_q[PW-1:BW]} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q >> 1;
			acc_q <= {sum, acc_q[BW-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

// ----- design/stbrm_hist.sv -----
// ----------------------------------------------------------------------------
// stbrm_hist
// ring of recent rates with valid bits, summed one entry per cycle
// ----------------------------------------------------------------------------
module stbrm_hist #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int N_W   = 5,
	parameter int SUM_W = 37
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [IDX_W-1:0]                 wr_idx,
	input  logic [stbrm_pkg::RATE_W-1:0]     wr_data,
	input  logic                             sum_start,
	input  logic [N_W-1:0]                   n,
	output stbrm_pkg::seq_stat_t             stat,
	output logic [SUM_W-1:0]                 sum
);

	localparam int RW = stbrm_pkg::RATE_W;

	logic [RW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic             issue_q;
	logic [IDX_W-1:0] idx_q;
	logic             rd_s1;
	logic             last_s1;
	logic             hit_s1;
	logic [RW-1:0]    data_s1;
	logic [SUM_W-1:0] sum_q;
	logic             done_q;
	logic             last_now;

	assign last_now = (N_W'(idx_q) == n - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			issue_q <= 1'b0;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (sum_start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
			end else if (issue_q) begin
				idx_q <= idx_q + 1'b1;
				if (last_now) begin
					issue_q <= 1'b0;
				end
			end
			rd_s1   <= issue_q;
			last_s1 <= issue_q & last_now;
			done_q  <= rd_s1 & last_s1;
		end
	end

	// entry storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		data_s1 <= mem[idx_q];
		hit_s1  <= valid_q[idx_q];
	end

	always_ff @(posedge clk) begin
		if (sum_start) begin
			sum_q <= '0;
		end else if (rd_s1) begin
			// an entry never written reads as zero
			sum_q <= sum_q + (hit_s1 ? SUM_W'(data_s1) : '0);
		end
	end

	assign stat.busy = issue_q | rd_s1;
	assign stat.done = done_q;
	assign sum       = sum_q;

endmodule

// ----- design/scaled_timebase_rate_meter.sv -----
// ----------------------------------------------------------------------------
// scaled_timebase_rate_meter
// frame timer: scaled time accumulator, frame delta in ticks and seconds,
// and instantaneous or averaged frame rate, all from timestamped events
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_axis    in   s_tvalid/s_tready    tuser kind, tdata timestamp
//  m_axis    out  m_tvalid/m_tready    tdata delta_ticks, delta_seconds,
//                                      frame_rate, scaled_time
//  cfg       in   cfg_we               cfg_index, cfg_data
//
//  non-tick events and paused ticks go from accept straight to the done state
//  a live tick runs through one shared one-bit-per-cycle divider: rate (skipped if
//  saturated), step fixed by the divider or scaled by the multiplier (multiply
//  overlaps the rate), seconds (skipped if saturated), then no averaging for a
//  zero count, or ring pointer modulo, ring write, ring sum and average divide
//  a reset event zeroes the scaled time at once; arst_n clears the ring by its valid bits
//  a finished word waits in the output register while the next event is
//  already accepted and worked on; a second finished word waits in the last state
//
module scaled_timebase_rate_meter #(
	parameter int HISTORY_DEPTH = stbrm_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [stbrm_pkg::IN_DATA_W-1:0]      s_tdata,  // [63:0] timestamp
	input  logic [stbrm_pkg::KIND_W-1:0]         s_tuser,  // [1:0] kind
	// master side
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [47:0] delta_ticks, [79:48] delta_seconds, [111:80] frame_rate,
	// [175:112] scaled_time
	output logic [stbrm_pkg::OUT_DATA_W-1:0]     m_tdata,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [stbrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stbrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int N_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = stbrm_pkg::RATE_W + N_W;
	localparam int DW    = (SUM_W > stbrm_pkg::FREQ_W) ? SUM_W : stbrm_pkg::FREQ_W;

	localparam int SW  = stbrm_pkg::STAMP_W;
	localparam int FW  = stbrm_pkg::FREQ_W;
	localparam int RTW = stbrm_pkg::RATE_W;
	localparam int PW  = stbrm_pkg::PROD_W;

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_RATE_SET = 14'b00000000000010,
		ST_RATE_RUN = 14'b00000000000100,
		ST_STEP_SET = 14'b00000000001000,
		ST_STEP_RUN = 14'b00000000010000,
		ST_SECS_SET = 14'b00000000100000,
		ST_SECS_RUN = 14'b00000001000000,
		ST_MOD_SET  = 14'b00000010000000,
		ST_MOD_RUN  = 14'b00000100000000,
		ST_HIST_WR  = 14'b00001000000000,
		ST_SUM_RUN  = 14'b00010000000000,
		ST_AVG_SET  = 14'b00100000000000,
		ST_AVG_RUN  = 14'b01000000000000,
		ST_DONE     = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic                               fixed_q;
	logic [FW-1:0]                      freq_q;
	logic [stbrm_pkg::FRATE_W-1:0]      frate_q;
	logic [stbrm_pkg::GAIN_W-1:0]       gain_q;
	logic [stbrm_pkg::AVG_W-1:0]        avg_q;

	// timebase state
	logic [SW-1:0]                      last_q;
	logic [stbrm_pkg::TIME_W-1:0]       acc_q;
	logic                               paused_q;
	logic [IDX_W-1:0]                   slot_q;

	// per-event working registers
	logic [SW-1:0]                      elapsed_q;
	logic [RTW-1:0]                     inst_q;
	logic [SW-1:0]                      step_q;
	logic [stbrm_pkg::SEC_W-1:0]        secs_q;
	logic [RTW-1:0]                     rate_q;

	// output register
	logic                               m_tvalid_q;
	logic [stbrm_pkg::OUT_DATA_W-1:0]   m_tdata_q;

	logic                               in_acc;
	logic                               out_free;
	stbrm_pkg::kind_t                   in_kind;
	logic [N_W-1:0]                     n;
	logic                               rate_sat;
	logic                               secs_sat;
	logic [FW-1:0]                      fixed_div;
	logic [SW-1:0]                      scaled_step;
	logic [IDX_W:0]                     slot_inc;

	// shared divider hookup
	stbrm_pkg::div_cmd_t                div_cmd;
	stbrm_pkg::seq_stat_t               div_stat;
	logic [stbrm_pkg::DIV_R_W-1:0]      div_rem;
	logic [stbrm_pkg::DIV_R_W-1:0]      div_dsr;
	logic [DW-1:0]                      div_dvd;
	logic [DW-1:0]                      div_quo;
	logic [stbrm_pkg::DIV_R_W-1:0]      div_left;

	// multiplier hookup
	logic                               mul_start;
	logic                               mul_busy;
	logic [PW-1:0]                      mul_prod;

	// ring hookup
	logic                               hist_wr;
	logic                               hist_start;
	stbrm_pkg::seq_stat_t               hist_stat;
	logic [SUM_W-1:0]                   hist_sum;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign in_kind  = stbrm_pkg::kind_t'(s_tuser);
	assign out_free = ~m_tvalid_q | m_tready;

	// averaging depth, clamped to the ring
	always_comb begin
		if (32'(avg_q) > HISTORY_DEPTH) begin
			n = N_W'(HISTORY_DEPTH);
		end else begin
			n = N_W'(avg_q);
		end
	end

	// quotient would not fit 32 bits (also covers zero period)
	assign rate_sat = (elapsed_q[SW-1:24] == '0) && (freq_q >= {elapsed_q[23:0], 16'h0});
	// quotient would not fit 32 bits (also covers zero frequency)
	assign secs_sat = (|step_q[SW-1:56]) || (step_q[55:0] >= {freq_q, 16'h0});

	assign fixed_div = (frate_q == '0) ? FW'(1) : FW'(frate_q);
	// product >> 16, saturated at the top of 64 bits
	assign scaled_step = (|mul_prod[PW-1:80]) ? stbrm_pkg::TIME_MAX : mul_prod[79:16];
	assign slot_inc = {1'b0, slot_q} + {{IDX_W{1'b0}}, 1'b1};

	assign mul_start  = (state_q == ST_RATE_SET) & ~fixed_q;
	assign hist_wr    = (state_q == ST_HIST_WR);
	assign hist_start = (state_q == ST_HIST_WR);

	// divider operand select
	always_comb begin
		div_cmd = '0;
		div_rem = '0;
		div_dsr = '0;
		div_dvd = '0;
		case (state_q)
			ST_RATE_SET: begin
				// freq << 16 over elapsed, top part preloaded as remainder
				div_cmd.start = ~rate_sat;
				div_cmd.count = stbrm_pkg::div_cnt_t'(32);
				div_rem       = 64'(freq_q[FW-1:16]);
				div_dsr       = elapsed_q;
				div_dvd       = DW'({freq_q[15:0], 16'h0}) << (DW - 32);
			end
			ST_STEP_SET: begin
				div_cmd.start = fixed_q;
				div_cmd.count = stbrm_pkg::div_cnt_t'(FW);
				div_dsr       = 64'(fixed_div);
				div_dvd       = DW'(freq_q) << (DW - FW);
			end
			ST_SECS_SET: begin
				// step << 16 over freq
				div_cmd.start = ~secs_sat;
				div_cmd.count = stbrm_pkg::div_cnt_t'(32);
				div_rem       = 64'(step_q[SW-1:16]);
				div_dsr       = 64'(freq_q);
				div_dvd       = DW'({step_q[15:0], 16'h0}) << (DW - 32);
			end
			ST_MOD_SET: begin
				// ring pointer step modulo the averaging depth
				div_cmd.start = (n != '0);
				div_cmd.count = stbrm_pkg::div_cnt_t'(IDX_W + 1);
				div_dsr       = 64'(n);
				div_dvd       = DW'(slot_inc) << (DW - IDX_W - 1);
			end
			ST_AVG_SET: begin
				div_cmd.start = 1'b1;
				div_cmd.count = stbrm_pkg::div_cnt_t'(SUM_W);
				div_dsr       = 64'(n);
				div_dvd       = DW'(hist_sum) << (DW - SUM_W);
			end
			default: begin
			end
		endcase
	end

	// configuration, sequencer and timebase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q    <= stbrm_pkg::FIXED_MODE_RST;
			freq_q     <= stbrm_pkg::TICK_FREQ_RST;
			frate_q    <= stbrm_pkg::FIXED_RATE_RST;
			gain_q     <= stbrm_pkg::RATE_GAIN_RST;
			avg_q      <= stbrm_pkg::AVG_COUNT_RST;
			state_q    <= ST_IDLE;
			last_q     <= '0;
			acc_q      <= '0;
			paused_q   <= 1'b0;
			slot_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (stbrm_pkg::cfg_idx_t'(cfg_index))
					stbrm_pkg::CFG_FIXED_MODE:    fixed_q <= cfg_data[0];
					stbrm_pkg::CFG_TICK_FREQ:     freq_q  <= cfg_data[FW-1:0];
					stbrm_pkg::CFG_FIXED_RATE:    frate_q <= cfg_data[stbrm_pkg::FRATE_W-1:0];
					stbrm_pkg::CFG_RATE_GAIN:     gain_q  <= cfg_data[stbrm_pkg::GAIN_W-1:0];
					stbrm_pkg::CFG_AVERAGE_COUNT: avg_q   <= cfg_data[stbrm_pkg::AVG_W-1:0];
					default: begin
					end
				endcase
			end

			// the done state reloads the output register on its own
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_kind)
							stbrm_pkg::KIND_PAUSE: begin
								paused_q <= 1'b1;
								state_q  <= ST_DONE;
							end
							stbrm_pkg::KIND_RESUME: begin
								paused_q <= 1'b0;
								last_q   <= s_tdata;
								state_q  <= ST_DONE;
							end
							stbrm_pkg::KIND_RESET: begin
								acc_q   <= '0;
								last_q  <= s_tdata;
								state_q <= ST_DONE;
							end
							default: begin
								// live tick: restart the timing base here
								if (!paused_q) begin
									last_q  <= s_tdata;
									state_q <= ST_RATE_SET;
								end else begin
									state_q <= ST_DONE;
								end
							end
						endcase
					end
				end
				ST_RATE_SET: begin
					state_q <= rate_sat ? ST_STEP_SET : ST_RATE_RUN;
				end
				ST_RATE_RUN: begin
					if (div_stat.done) begin
						state_q <= ST_STEP_SET;
					end
				end
				ST_STEP_SET: begin
					state_q <= ST_STEP_RUN;
				end
				ST_STEP_RUN: begin
					if (fixed_q ? div_stat.done : ~mul_busy) begin
						state_q <= ST_SECS_SET;
					end
				end
				ST_SECS_SET: begin
					acc_q   <= acc_q + step_q;
					state_q <= secs_sat ? ST_MOD_SET : ST_SECS_RUN;
				end
				ST_SECS_RUN: begin
					if (div_stat.done) begin
						state_q <= ST_MOD_SET;
					end
				end
				ST_MOD_SET: begin
					state_q <= (n == '0) ? ST_DONE : ST_MOD_RUN;
				end
				ST_MOD_RUN: begin
					if (div_stat.done) begin
						slot_q  <= div_left[IDX_W-1:0];
						state_q <= ST_HIST_WR;
					end
				end
				ST_HIST_WR: begin
					state_q <= ST_SUM_RUN;
				end
				ST_SUM_RUN: begin
					if (hist_stat.done) begin
						state_q <= ST_AVG_SET;
					end
				end
				ST_AVG_SET: begin
					state_q <= ST_AVG_RUN;
				end
				ST_AVG_RUN: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-event payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					// non-tick events and paused ticks report zeros
					elapsed_q <= s_tdata - last_q;
					step_q    <= '0;
					secs_q    <= '0;
					rate_q    <= '0;
				end
			end
			ST_RATE_SET: begin
				if (rate_sat) begin
					inst_q <= stbrm_pkg::RATE_MAX;
				end
			end
			ST_RATE_RUN: begin
				if (div_stat.done) begin
					inst_q <= div_quo[RTW-1:0];
				end
			end
			ST_STEP_RUN: begin
				if (fixed_q) begin
					if (div_stat.done) begin
						step_q <= SW'(div_quo[FW-1:0]);
					end
				end else if (!mul_busy) begin
					step_q <= scaled_step;
				end
			end
			ST_SECS_SET: begin
				if (secs_sat) begin
					secs_q <= stbrm_pkg::RATE_MAX;
				end
			end
			ST_SECS_RUN: begin
				if (div_stat.done) begin
					secs_q <= div_quo[stbrm_pkg::SEC_W-1:0];
				end
			end
			ST_MOD_SET: begin
				if (n == '0) begin
					rate_q <= inst_q;
				end
			end
			ST_AVG_RUN: begin
				if (div_stat.done) begin
					rate_q <= div_quo[RTW-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {acc_q, rate_q, secs_q,
						(|step_q[SW-1:stbrm_pkg::DT_W]) ? stbrm_pkg::DT_MAX
							: step_q[stbrm_pkg::DT_W-1:0]};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	stbrm_div #(
		.DW(DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.rem_init  (div_rem),
		.divisor   (div_dsr),
		.dividend  (div_dvd),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_left)
	);

	stbrm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (elapsed_q),
		.b       (gain_q),
		.busy    (mul_busy),
		.product (mul_prod)
	);

	stbrm_hist #(
		.DEPTH (HISTORY_DEPTH),
		.IDX_W (IDX_W),
		.N_W   (N_W),
		.SUM_W (SUM_W)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (hist_wr),
		.wr_idx    (slot_q),
		.wr_data   (inst_q),
		.sum_start (hist_start),
		.n         (n),
		.stat      (hist_stat),
		.sum       (hist_sum)
	);

endmodule
